FILE: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and codes for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int DEPTH_W = 7;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 3'd0,
        CMD_ADD  = 3'd1,
        CMD_SUB  = 3'd2,
        CMD_MUL  = 3'd3,
        CMD_DIV  = 3'd4,
        CMD_MOD  = 3'd5,
        CMD_NOP6 = 3'd6,
        CMD_NOP7 = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    // Request to the iterative divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

endpackage

FILE: rtl/rpn_stack_calculator_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top
// Reverse Polish calculator on a bounded Q16.16 value stack.
// ----------------------------------------------------------------------------
// One item is worked at a time. A push is written in the read stage and then
// answered; add and subtract take the cached top and one stack read through the
// registered memory port, then the update; multiply adds one registered 32x32
// product. Divide and modulo run through a shared radix-2 divider that retires
// one quotient bit per cycle over 64 bits. The block returns to idle after each
// accepted result before the next transfer. Overflow and underflow answer
// without a stack read; divide and modulo by zero answer after it. Input is held
// off while an item is in flight or its result waits.
// The stack lives in one synchronous memory written at one address and read at
// one address per cycle; its contents are undefined until pushed.
module rpn_stack_calculator_top #(
    parameter int DEPTH     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rpn_pkg::CMD_W-1:0]     cmd,
    input  logic signed [31:0]            value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            top_value,
    output logic [rpn_pkg::DEPTH_W-1:0]   stack_depth,
    output logic [rpn_pkg::STAT_W-1:0]    status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rpn_pkg::DEPTH_W-1:0]   cfg_data
);
    import rpn_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_RDB   = 8'b0000_0010,
        S_RDA   = 8'b0000_0100,
        S_EXEC  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_WRITE = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DEPTH_W-1:0] limit_reg;
    cmd_t            cmd_reg, cmd_next;
    logic [31:0]     push_reg, push_next;
    logic [31:0]     a_reg, a_next, b_reg, b_next;
    logic [31:0]     top_reg, top_next;     // cached top of stack
    logic [31:0]     res_reg, res_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [63:0]     prod_reg;

    // stack memory
    logic [31:0]     mem [DEPTH];
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [31:0]     wdata, rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    // effective limit: 0 acts as 1, above DEPTH acts as DEPTH
    logic [CW-1:0] lim_eff;
    always_comb
    begin
        if (limit_reg == '0)
            lim_eff = CW'(1);
        else if ({{(32-DEPTH_W){1'b0}}, limit_reg} > DEPTH)
            lim_eff = DEPTH_C;
        else
            lim_eff = CW'(limit_reg);
    end

    // operand sign and magnitude
    logic        a_neg, b_neg, r_neg;
    logic [31:0] a_mag, b_mag;
    assign a_neg = a_reg[31];
    assign b_neg = b_reg[31];
    assign r_neg = a_neg ^ b_neg;
    assign a_mag = a_neg ? (32'd0 - a_reg) : a_reg;
    assign b_mag = b_neg ? (32'd0 - b_reg) : b_reg;

    always_ff @(posedge clk)
        prod_reg <= 64'(a_mag) * 64'(b_mag);

    // apply sign to a magnitude and saturate to 32 bits
    function automatic logic [31:0] sat_sign(input logic [63:0] m, input logic neg);
        logic [31:0] r;
        begin
            if (neg)
                r = (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
            else
                r = (m >= 64'h8000_0000) ? 32'h7FFF_FFFF : m[31:0];
            return r;
        end
    endfunction

    // divider
    div_req_t dreq;
    div_rsp_t drsp;
    rpn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [31:0] ia, ib;
    assign ia = a_mag >> FRAC_BITS;
    assign ib = b_mag >> FRAC_BITS;

    logic [32:0] sum;
    logic        in_fire;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        push_next  = push_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        top_next   = top_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        we         = 1'b0;
        waddr      = cnt_reg[AW-1:0];
        wdata      = res_reg;
        raddr      = AW'(cnt_reg - CW'(1));
        dreq.start    = 1'b0;
        dreq.dividend = 64'(a_mag) << FRAC_BITS;
        dreq.divisor  = b_mag;
        sum = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = cmd_t'(cmd);
                    push_next = value;
                    stat_next = ST_OK;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                // issue read of the entry below the top
                raddr = AW'(cnt_reg - CW'(2));
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (cnt_reg >= lim_eff)
                            stat_next = ST_OVER;
                        else
                        begin
                            we       = 1'b1;
                            wdata    = push_reg;
                            top_next = push_reg;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        state_next = S_OUT;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD:
                    begin
                        if (cnt_reg < CW'(2))
                        begin
                            stat_next  = ST_UNDER;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            b_next     = top_reg;
                            state_next = S_RDA;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_RDA:
            begin
                a_next     = rdata_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_WRITE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        sum      = {a_reg[31], a_reg} + {b_reg[31], b_reg};
                        res_next = (sum[32] != sum[31]) ?
                                   (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
                    end
                    CMD_SUB:
                    begin
                        sum      = {a_reg[31], a_reg} - {b_reg[31], b_reg};
                        res_next = (sum[32] != sum[31]) ?
                                   (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
                    end
                    CMD_MUL: state_next = S_MUL;
                    CMD_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            stat_next  = ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    CMD_MOD:
                    begin
                        if (ib == '0)
                        begin
                            stat_next  = ST_ZERO;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = 64'(ia);
                            dreq.divisor  = ib;
                            state_next    = S_DIV;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_MUL:
            begin
                res_next   = sat_sign(prod_reg >> FRAC_BITS, r_neg);
                state_next = S_WRITE;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    if (cmd_reg == CMD_DIV)
                        res_next = sat_sign(drsp.quotient, r_neg);
                    else
                        res_next = sat_sign(64'(drsp.remainder) << FRAC_BITS, a_neg);
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // drop b, overwrite a with the result
                we         = 1'b1;
                waddr      = AW'(cnt_reg - CW'(2));
                wdata      = res_reg;
                top_next   = res_reg;
                cnt_next   = cnt_reg - CW'(1);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            limit_reg <= DEPTH_W'(DEPTH);
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        push_reg <= push_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        top_reg  <= top_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
    end

    assign out_valid   = (state_reg == S_OUT);
    assign top_value   = (cnt_reg == '0) ? 32'sd0 : top_reg;
    assign stack_depth = DEPTH_W'(cnt_reg);
    assign status      = stat_reg;

    // depth never exceeds the built depth
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("stack count above depth");

    // an accepted result returns the block to idle
    a_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> state_reg == S_IDLE)
        else $error("no return to idle");

    // failing steps leave the depth unchanged
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && stat_reg != ST_OK) |-> $stable(cnt_reg))
        else $error("depth changed on error");

endmodule

FILE: rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// Unsigned restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    import rpn_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] shifted;
    logic [33:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg[31:0], quo_reg[63]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[31:0];

endmodule

FILE: verif/rpn_calc_checker.sv
// ----------------------------------------------------------------------------
// rpn_calc_checker
// Watches the command and result channels of the RPN calculator, keeps its own
// copy of the stack and limit, predicts each result and compares it.
// ----------------------------------------------------------------------------
module rpn_calc_checker #(
    parameter int DEPTH     = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rpn_pkg::CMD_W-1:0]     cmd,
    input  logic signed [31:0]            value,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [31:0]            top_value,
    input  logic [rpn_pkg::DEPTH_W-1:0]   stack_depth,
    input  logic [rpn_pkg::STAT_W-1:0]    status,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [rpn_pkg::DEPTH_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count
);
    import rpn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0]  top;
        logic [DEPTH_W-1:0]  depth;
        status_t             st;
    } calc_result_t;

    logic signed [31:0] shadow_stack [DEPTH];
    int                 shadow_count;
    logic [DEPTH_W-1:0] shadow_limit;
    calc_result_t       expected_results [$];

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Magnitude is at most 2^62, so signed negation is safe.
    function automatic logic signed [31:0] apply_sign(longint unsigned m, bit neg);
        longint s;
        s = longint'(m);
        return clamp32(neg ? -s : s);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic calc_result_t compute_step(cmd_t c, logic signed [31:0] v);
        calc_result_t       r;
        int                 lim;
        longint             a, b;
        longint unsigned    ia, ib;
        logic signed [31:0] res;
        bit                 neg;
        r.st = ST_OK;
        res = '0;
        lim = shadow_limit == 0 ? 1 : (shadow_limit > DEPTH ? DEPTH : shadow_limit);
        if (c == CMD_PUSH) begin
            if (shadow_count >= lim) r.st = ST_OVER;
            else begin
                shadow_stack[shadow_count] = v;
                shadow_count++;
            end
        end else if (c != CMD_NOP6 && c != CMD_NOP7) begin
            if (shadow_count < 2) r.st = ST_UNDER;
            else begin
                a = shadow_stack[shadow_count-2];
                b = shadow_stack[shadow_count-1];
                neg = (a < 0) != (b < 0);
                case (c)
                    CMD_ADD: res = clamp32(a + b);
                    CMD_SUB: res = clamp32(a - b);
                    CMD_MUL: res = apply_sign((magnitude(a) * magnitude(b)) >> FRAC_BITS, neg);
                    CMD_DIV:
                        if (b == 0) r.st = ST_ZERO;
                        else res = apply_sign((magnitude(a) << FRAC_BITS) / magnitude(b), neg);
                    default: begin
                        ia = magnitude(a) >> FRAC_BITS;
                        ib = magnitude(b) >> FRAC_BITS;
                        if (ib == 0) r.st = ST_ZERO;
                        else res = apply_sign((ia % ib) << FRAC_BITS, a < 0);
                    end
                endcase
                if (r.st == ST_OK) begin
                    shadow_stack[shadow_count-2] = res;
                    shadow_count--;
                end
            end
        end
        r.top = shadow_count > 0 ? shadow_stack[shadow_count-1] : '0;
        r.depth = DEPTH_W'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        calc_result_t exp_r;
        if (!rst_n) begin
            shadow_count = 0;
            shadow_limit = DEPTH_W'(DEPTH);
            expected_results.delete();
            pending      = 0;
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) shadow_limit = cfg_data;
            if (in_valid && !in_stall) expected_results.push_back(compute_step(cmd_t'(cmd), value));
            if (out_valid && !out_stall) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result top=%h depth=%0d status=%0d",
                             $time, top_value, stack_depth, status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.top !== top_value || exp_r.depth !== stack_depth
                        || exp_r.st !== status) begin
                        $display(
                            "%0t: mismatch exp top=%h depth=%0d st=%0d, got top=%h depth=%0d st=%0d",
                            $time, exp_r.top, exp_r.depth, exp_r.st,
                            top_value, stack_depth, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending = expected_results.size();
        end
    end
endmodule

FILE: verif/rpn_stack_calculator_top_tb.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_top_tb
// Drives directed and random RPN command sequences with random gaps and stalls
// across several stack limits; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_top_tb;
    import rpn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = 64;
    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] top_value;
    logic [DEPTH_W-1:0] stack_depth;
    logic [STAT_W-1:0]  status;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [DEPTH_W-1:0] cfg_data;
    int                 fail_count;
    int                 pending;
    int                 result_count;
    int                 idle_cycles;
    int                 items_sent;
    bit                 long_holdoff;

    rpn_stack_calculator_top #(.DEPTH(DEPTH), .FRAC_BITS(16)) dut (.*);

    rpn_calc_checker #(.DEPTH(DEPTH), .FRAC_BITS(16)) checker_i (.*);

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Watchdog: count cycles with no transfer on any channel.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired, %0d results pending", pending);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random stall per result; one long hold-off on request so the
    // block fills up and stalls its input.
    initial begin
        int hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (long_holdoff) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_holdoff = 0;
            end
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold == 0) out_stall <= 1'b0;
            else begin
                repeat (hold - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            // hold low until a transfer happens
            do @(posedge clk); while (!(out_valid && !out_stall));
            out_stall <= 1'b1;
        end
    end

    // Send one command: random gap, then hold valid until the transfer.
    // Valid stays high after the transfer so back-to-back items need no
    // second drive in the same step; drop it before any idle wait.
    task automatic send_cmd(cmd_t c, logic signed [31:0] v, bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Wait for the block to go idle, then write the stack limit.
    task automatic write_limit(logic [DEPTH_W-1:0] lim);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 9) << 16;
            1: return -($urandom_range(1, 9) << 16);
            2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            3: return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_t rand_op();
        return cmd_t'($urandom_range(1, 5));
    endfunction

    // Well-formed expression: push one operand, then n-1 pairs of push and operator.
    task automatic send_expression(int n);
        send_cmd(CMD_PUSH, rand_value());
        for (int k = 1; k < n; k++) begin
            send_cmd(CMD_PUSH, rand_value());
            send_cmd(rand_op(), rand_value());
        end
    endtask

    task automatic drain_stack();
        for (int k = 0; k < 70; k++) send_cmd(CMD_ADD, $urandom());
    endtask

    task automatic random_phase(int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) begin
            case ($urandom_range(0, 9))
                0: send_cmd(cmd_t'($urandom_range(0, 7)), $urandom());
                1: send_cmd(CMD_PUSH, rand_value());
                default: send_expression($urandom_range(2, 5));
            endcase
        end
    endtask

    initial begin
        items_sent   = 0;
        long_holdoff = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        cmd       = CMD_PUSH;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: underflow on empty and single entry, all operators,
        // saturation, divide and modulo by zero, unused codes.
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_PUSH, 32'sh7fffffff);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_PUSH, 32'sh7fffffff);
        send_cmd(CMD_ADD, 0);
        send_cmd(CMD_PUSH, 32'sh80000000);
        send_cmd(CMD_MUL, 0);
        send_cmd(CMD_PUSH, 32'sh00008000);
        send_cmd(CMD_DIV, 0);
        send_cmd(CMD_PUSH, 0);
        send_cmd(CMD_DIV, 0);
        send_cmd(CMD_PUSH, 32'sh0000ffff);
        send_cmd(CMD_MOD, 0);
        send_cmd(CMD_PUSH, -(32'sd3 << 16));
        send_cmd(CMD_MOD, 0);
        send_cmd(CMD_SUB, 0);
        send_cmd(CMD_NOP6, 32'sh12345678);
        send_cmd(CMD_NOP7, 0);
        send_cmd(CMD_PUSH, 32'sh80000000);
        send_cmd(CMD_SUB, 0);
        drain_stack();

        // Fill to the built depth and overflow, under back pressure.
        long_holdoff = 1;
        for (int k = 0; k < DEPTH + 2; k++) send_cmd(CMD_PUSH, $urandom(), 0);
        drain_stack();
        random_phase(80);

        // Limit extremes: zero acts as one, above depth acts as depth.
        write_limit(0);
        random_phase(60);
        write_limit(1);
        random_phase(60);
        write_limit(7'd127);
        for (int k = 0; k < 10; k++) send_cmd(CMD_PUSH, rand_value());
        write_limit(3);       // lowered below the current depth
        random_phase(90);
        drain_stack();
        write_limit(DEPTH_W'(DEPTH));
        random_phase(80);

        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge clk);
        $display("sent %0d commands, checked %0d results over limits 0,1,3,127,64",
                 items_sent, result_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
